// File: hdl/skvt_pkg.sv
// Shared types and constants for the sorted key/value table.
package skvt_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]                 opcode;
    logic signed [KEY_W-1:0]    key;
    logic signed [VALUE_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic                       hit;
    logic signed [VALUE_W-1:0]  old_value;
    logic                       full_error;
    logic [COUNT_W-1:0]         entry_count;
  } rsp_t;

  typedef struct packed {
    logic load;     // latch a new request
    logic capture;  // register compare results
    logic commit;   // update the table and the result register
  } ctl_cmd_t;

endpackage

// File: hdl/skvt_ctrl.sv
// Controller: sequences compare and update, owns the handshakes.
module skvt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output skvt_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   commit, accept;

  // update only when the result register is free or being emptied
  assign commit     = (state_q == ST_UPD) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !((state_q == ST_IDLE) || commit);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_CMP;
      end
      ST_CMP: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (commit) state_d = accept ? ST_CMP : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = commit | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cmd_o.load      = accept;
  assign cmd_o.capture   = (state_q == ST_CMP);
  assign cmd_o.commit    = commit;

endmodule

// File: hdl/skvt_dpath.sv
// Datapath: entry cells, parallel compare, shift insert/remove, result register.
module skvt_dpath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  skvt_pkg::ctl_cmd_t  cmd_i,
  input  skvt_pkg::req_t      in_data_i,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i,
  output skvt_pkg::rsp_t      out_data_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic signed [skvt_pkg::KEY_W-1:0]   keys_q [CAPACITY];
  logic signed [skvt_pkg::VALUE_W-1:0] vals_q [CAPACITY];
  logic [CW-1:0]                       count_q, count_d;
  logic                                sort_desc_q;
  skvt_pkg::req_t                      req_q;
  skvt_pkg::rsp_t                      rsp_q, rsp_d;

  logic [CAPACITY-1:0]                 vmask, eq, prec;
  logic [CAPACITY-1:0]                 eq_q, prec_q;
  logic                                hit_d, hit_q;
  logic signed [skvt_pkg::VALUE_W-1:0] old_d, old_q;

  // compare cycle: key against every valid entry at once
  always_comb begin
    old_d = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      vmask[i] = CW'(i) < count_q;
      eq[i]    = vmask[i] && (keys_q[i] == req_q.key);
      prec[i]  = vmask[i] && (sort_desc_q ? (req_q.key > keys_q[i])
                                          : (req_q.key < keys_q[i]));
      old_d    = old_d | (eq[i] ? vals_q[i] : '0);
    end
    hit_d = |eq;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_data_i;
    if (cmd_i.capture) begin
      eq_q   <= eq;
      prec_q <= prec;
      hit_q  <= hit_d;
      old_q  <= old_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sort_desc_q <= 1'b0;
    end else if (cfg_we_i) begin
      sort_desc_q <= cfg_data_i;
    end
  end

  // update cycle: masks of positions at and beyond the insert / remove point
  logic [CAPACITY-1:0] ins_low, ins_from, after, rem_low, rem_from;
  logic                op_add, op_rem, op_known, full, do_ins, do_rep, do_rem;

  assign ins_low  = prec_q & (~prec_q + 1'b1);
  assign ins_from = ~(ins_low - 1'b1);
  assign after    = ins_from | ~vmask;   // no preceding entry: append at count
  assign rem_low  = eq_q & (~eq_q + 1'b1);
  assign rem_from = ~(rem_low - 1'b1);

  assign op_add   = (req_q.opcode == skvt_pkg::OP_ADD);
  assign op_rem   = (req_q.opcode == skvt_pkg::OP_REMOVE);
  assign op_known = op_add || op_rem || (req_q.opcode == skvt_pkg::OP_SEARCH);
  assign full     = op_add && !hit_q && (count_q == CW'(CAPACITY));
  assign do_ins   = op_add && !hit_q && !full;
  assign do_rep   = op_add && hit_q;
  assign do_rem   = op_rem && hit_q;

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic                                first_ins, shift_ins;
    logic signed [skvt_pkg::KEY_W-1:0]   prev_key, next_key;
    logic signed [skvt_pkg::VALUE_W-1:0] prev_val, next_val;

    if (gi == 0) begin : g_first
      assign first_ins = after[gi];
      assign shift_ins = 1'b0;
      assign prev_key  = keys_q[gi];
      assign prev_val  = vals_q[gi];
    end else begin : g_rest
      assign first_ins = after[gi] & ~after[gi-1];
      assign shift_ins = after[gi-1];
      assign prev_key  = keys_q[gi-1];
      assign prev_val  = vals_q[gi-1];
    end

    if (gi == CAPACITY - 1) begin : g_last
      assign next_key = keys_q[gi];
      assign next_val = vals_q[gi];
    end else begin : g_mid
      assign next_key = keys_q[gi+1];
      assign next_val = vals_q[gi+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.commit) begin
        if (do_ins) begin
          if (first_ins) begin
            keys_q[gi] <= req_q.key;
            vals_q[gi] <= req_q.value;
          end else if (shift_ins) begin
            keys_q[gi] <= prev_key;
            vals_q[gi] <= prev_val;
          end
        end else if (do_rep) begin
          if (eq_q[gi]) vals_q[gi] <= req_q.value;
        end else if (do_rem) begin
          if (rem_from[gi]) begin
            keys_q[gi] <= next_key;
            vals_q[gi] <= next_val;
          end
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_ins)      count_d = count_q + 1'b1;
    else if (do_rem) count_d = count_q - 1'b1;
    rsp_d.hit         = hit_q && op_known;
    rsp_d.old_value   = (hit_q && op_known) ? old_q : '0;
    rsp_d.full_error  = full;
    rsp_d.entry_count = skvt_pkg::COUNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) rsp_q <= rsp_d;
  end

  assign out_data_o = rsp_q;

endmodule

// File: hdl/sorted_key_value_table.sv
// Sorted key/value table: up to CAPACITY unique pairs kept in key order in a
// row of shift cells. Each transaction has a compare step, which checks the
// key against every stored entry in parallel, then an update step, which
// shifts the cells to insert or remove, or rewrites one value, and loads the
// result register. A new request is taken in the update cycle, not during the
// compare, so each request waits for the one before it to reach its update;
// the update waits while a previous result is still held under stall. No
// clearing pass is needed after reset. The order register may be written
// whenever the block is idle and does not re-sort entries already stored.
module sorted_key_value_table #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  skvt_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output skvt_pkg::rsp_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_data_i
);

  skvt_pkg::ctl_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  skvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  skvt_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

endmodule

// File: hdl/skvt_checker.sv
// Port-level checks for the sorted key/value table, bound to the top level.
module skvt_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input skvt_pkg::rsp_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken during compare");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.old_value == '0)
    else $error("old value reported on a miss");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.full_error |->
      !out_data_o.hit && out_data_o.entry_count == skvt_pkg::COUNT_W'(CAPACITY))
    else $error("full flag without a full table");

endmodule

bind sorted_key_value_table skvt_checker #(
  .CAPACITY (CAPACITY)
) u_skvt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
